// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent implication or plain property, checked on the rising clock edge.
`define DSA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// A condition that must never hold outside reset.
`define DSA_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define DSA_ASSERT(label, clk, rst_n, prop)
`define DSA_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: src/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Widths, limits and handover types of the decimal digit string adder.
// ----------------------------------------------------------------------------
package dsa_pkg;

	// Binary width of the accumulator, the addend and the saturated sum.
	localparam int unsigned ACC_W = 31;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned MAX_DIGITS_DEF = 10;
	// A 31-bit value never has more than ten decimal digits.
	localparam int unsigned DIGITS_CAP = 10;
	localparam logic [63:0] ACC_MAX64 = 64'd2147483647;

	// Saturation limit: the smaller of 2^31-1 and 10^max_digits-1.
	function automatic logic [ACC_W-1:0] sat_limit(input int unsigned max_digits);
		logic [63:0] p;
		p = 64'd1;
		for (int unsigned i = 0; i < max_digits && i < 19; i++) begin
			p = p * 64'd10;
		end
		p = p - 64'd1;
		if (p > ACC_MAX64) begin
			p = ACC_MAX64;
		end
		return p[ACC_W-1:0];
	endfunction

	// Number of decimal digits kept for the sum.
	function automatic int unsigned num_digits(input int unsigned max_digits);
		return (max_digits < DIGITS_CAP) ? max_digits : DIGITS_CAP;
	endfunction

	// Saturated sum handed from the accumulator to the converter.
	typedef struct packed {
		logic             go;
		logic             ovf;
		logic [ACC_W-1:0] value;
	} start_t;

	// Completion strobe from the converter to the emitter.
	typedef struct packed {
		logic go;
		logic ovf;
	} conv_t;

endpackage

// File: src/dsa_if.sv
// ----------------------------------------------------------------------------
// dsa_if
// Valid/ready channels for incoming digit requests and outgoing sum digits.
// ----------------------------------------------------------------------------
interface dsa_in_if;
	logic                            valid;
	logic                            ready;
	logic [dsa_pkg::DIGIT_W-1:0]     digit;
	logic                            last_digit;
	logic [dsa_pkg::ACC_W-1:0]       addend;

	modport source (output valid, output digit, output last_digit, output addend,
		input ready);
	modport sink (input valid, input digit, input last_digit, input addend,
		output ready);
endinterface

interface dsa_out_if;
	logic                            valid;
	logic                            ready;
	logic [dsa_pkg::DIGIT_W-1:0]     sum_digit;
	logic                            last_of_sum;
	logic                            overflow;

	modport source (output valid, output sum_digit, output last_of_sum,
		output overflow, input ready);
	modport sink (input valid, input sum_digit, input last_of_sum, input overflow,
		output ready);
endinterface

// File: src/decimal_digit_string_adder_top.sv
// ----------------------------------------------------------------------------
// decimal_digit_string_adder_top
// Decimal digits arrive most significant first, one request each, and are
// folded into a saturating binary accumulator as acc*10+digit. The request
// marked last_digit also carries a binary addend; the block adds it, clamps
// the sum at min(2^31-1, 10^MAX_DIGITS-1) and returns the sum's decimal
// digits most significant first, without leading zeros (zero gives one 0),
// with last_of_sum on the final digit and overflow on every digit when the
// accumulator or the sum saturated. A digit that is not last leaves the input
// ready. After the last digit, input is held off while the sum is formed,
// while the bit-serial binary to BCD converter runs, for the handover, while
// leading zeros of the digits kept (min(MAX_DIGITS,10) positions) are skipped
// and while the digits are emitted, longer while the sink stalls; the
// shift-and-add-three converter is the longest step unless the sink stalls.
// The input takes the next request once the final sum digit has been taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_digit_string_adder_top #(
	parameter int unsigned MAX_DIGITS = dsa_pkg::MAX_DIGITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dsa_in_if.sink    num,
	dsa_out_if.source sum
);

	localparam int unsigned NDIG = dsa_pkg::num_digits(MAX_DIGITS);

	// The handovers between the three stages travel as structs, with the BCD digits as a plain vector.
	dsa_pkg::start_t   start;
	dsa_pkg::conv_t    done;
	logic [4*NDIG-1:0] bcd;
	logic              pending;
	logic              conv_busy;
	logic              emit_busy;
	logic              take;

	// One number is in flight at a time: requests are held off from the last
	// digit until the final sum digit has left the output register.
	assign num.ready = !(pending | conv_busy | emit_busy);
	assign take      = num.valid & num.ready;

	dsa_accum #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.digit     (num.digit),
		.last_digit(num.last_digit),
		.addend    (num.addend),
		.start     (start),
		.pending   (pending)
	);

	dsa_b2d #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_b2d (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.bcd   (bcd),
		.done  (done),
		.busy  (conv_busy)
	);

	// The emitter's output register decouples the sink from the shifter.
	dsa_emit #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.bcd        (bcd),
		.done       (done),
		.ready      (sum.ready),
		.valid      (sum.valid),
		.sum_digit  (sum.sum_digit),
		.last_of_sum(sum.last_of_sum),
		.overflow   (sum.overflow),
		.busy       (emit_busy)
	);

	// No new request is taken while sum digits are still being delivered.
	`DSA_ASSERT(a_no_take_while_emit, clk, arst_n, sum.valid |-> !num.ready)
	// The last digit closes the input until its sum has gone out.
	`DSA_ASSERT(a_last_blocks_input, clk, arst_n, take && num.last_digit |=> !num.ready)
	// After the final digit is taken no further digit follows at once.
	`DSA_ASSERT(a_quiet_after_last, clk, arst_n,
		sum.valid && sum.ready && sum.last_of_sum |=> !sum.valid)
	// The converter only ever produces decimal digits.
	`DSA_NEVER(a_digit_decimal, clk, arst_n, sum.valid && sum.sum_digit > 4'd9)

endmodule

// File: src/dsa_accum.sv
// ----------------------------------------------------------------------------
// dsa_accum
// Folds digits into a saturating binary accumulator and forms the final sum.
// ----------------------------------------------------------------------------
module dsa_accum #(
	parameter int unsigned MAX_DIGITS = dsa_pkg::MAX_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic [dsa_pkg::DIGIT_W-1:0]     digit,
	input  logic                            last_digit,
	input  logic [dsa_pkg::ACC_W-1:0]       addend,
	output dsa_pkg::start_t                 start,
	output logic                            pending
);

	localparam int unsigned ACC_W = dsa_pkg::ACC_W;
	localparam int unsigned PROD_W = ACC_W + 4;
	localparam logic [ACC_W-1:0] LIMIT = dsa_pkg::sat_limit(MAX_DIGITS);

	logic [ACC_W-1:0]  acc_q;
	logic              sat_q;
	logic              fin_q;
	logic [ACC_W-1:0]  addend_q;

	logic [PROD_W-1:0] prod;
	logic              prod_over;
	logic [ACC_W-1:0]  fold;
	logic [ACC_W:0]    sum;
	logic              sum_over;

	// acc*10 + digit as acc*8 + acc*2 + digit.
	always_comb begin
		prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
			+ {{(PROD_W-dsa_pkg::DIGIT_W){1'b0}}, digit};
		prod_over = prod > {4'b0, LIMIT};
		fold = prod_over ? LIMIT : prod[ACC_W-1:0];
		sum = {1'b0, acc_q} + {1'b0, addend_q};
		sum_over = sum > {1'b0, LIMIT};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			sat_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (take) begin
			acc_q <= fold;
			sat_q <= sat_q | prod_over;
			fin_q <= last_digit;
		end else if (fin_q) begin
			acc_q <= '0;
			sat_q <= 1'b0;
			fin_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_digit) begin
			addend_q <= addend;
		end
	end

	assign start.go    = fin_q;
	assign start.ovf   = sat_q | sum_over;
	assign start.value = sum_over ? LIMIT : sum[ACC_W-1:0];
	assign pending     = fin_q;

endmodule

// File: src/dsa_b2d.sv
// ----------------------------------------------------------------------------
// dsa_b2d
// Bit-serial binary to BCD converter (shift and add-three, one bit a cycle).
// ----------------------------------------------------------------------------
module dsa_b2d #(
	parameter int unsigned MAX_DIGITS = dsa_pkg::MAX_DIGITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dsa_pkg::start_t           start,
	output logic [4*dsa_pkg::num_digits(MAX_DIGITS)-1:0] bcd,
	output dsa_pkg::conv_t            done,
	output logic                      busy
);

	localparam int unsigned ACC_W = dsa_pkg::ACC_W;
	localparam int unsigned NDIG = dsa_pkg::num_digits(MAX_DIGITS);
	localparam int unsigned BCD_W = 4 * NDIG;
	localparam int unsigned CNT_W = $clog2(ACC_W);

	logic [ACC_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic             ovf_q;
	logic [BCD_W-1:0] adj;

	// Every digit of five or more gets three added before the shift.
	always_comb begin
		for (int unsigned i = 0; i < NDIG; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ACC_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start.go) begin
			bin_q <= start.value;
			bcd_q <= '0;
			ovf_q <= start.ovf;
		end else if (run_q) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[BCD_W-2:0], bin_q[ACC_W-1]};
		end
	end

	assign bcd      = bcd_q;
	assign done.go  = done_q;
	assign done.ovf = ovf_q;
	assign busy     = run_q | done_q;

endmodule

// File: src/dsa_emit.sv
// ----------------------------------------------------------------------------
// dsa_emit
// Shifts BCD digits out most significant first, dropping leading zeros.
// ----------------------------------------------------------------------------
module dsa_emit #(
	parameter int unsigned MAX_DIGITS = dsa_pkg::MAX_DIGITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [4*dsa_pkg::num_digits(MAX_DIGITS)-1:0] bcd,
	input  dsa_pkg::conv_t            done,
	input  logic                      ready,
	output logic                      valid,
	output logic [dsa_pkg::DIGIT_W-1:0] sum_digit,
	output logic                      last_of_sum,
	output logic                      overflow,
	output logic                      busy
);

	localparam int unsigned NDIG = dsa_pkg::num_digits(MAX_DIGITS);
	localparam int unsigned BCD_W = 4 * NDIG;
	localparam int unsigned LEFT_W = $clog2(NDIG + 1);

	logic [BCD_W-1:0]  sh_q;
	logic [LEFT_W-1:0] left_q;
	logic              act_q;
	logic              seen_q;
	logic              ovf_q;
	logic              ov_q;
	logic [3:0]        dig_q;
	logic              last_q;
	logic              oflow_q;

	logic [3:0]        top;
	logic              skip;
	logic              emit_go;
	logic              final_dig;

	always_comb begin
		top = sh_q[BCD_W-1 -: 4];
		final_dig = left_q == LEFT_W'(1);
		skip = act_q && !seen_q && top == 4'd0 && !final_dig;
		emit_go = act_q && !skip && (!ov_q || ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			seen_q <= 1'b0;
			left_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (done.go) begin
				act_q  <= 1'b1;
				seen_q <= 1'b0;
				left_q <= LEFT_W'(NDIG);
			end else if (skip || emit_go) begin
				left_q <= left_q - 1'b1;
				if (emit_go) begin
					seen_q <= 1'b1;
					if (final_dig) begin
						act_q <= 1'b0;
					end
				end
			end
			if (emit_go) begin
				ov_q <= 1'b1;
			end else if (ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done.go) begin
			sh_q  <= bcd;
			ovf_q <= done.ovf;
		end else if (skip || emit_go) begin
			sh_q <= sh_q << 4;
		end
		if (emit_go) begin
			dig_q   <= top;
			last_q  <= final_dig;
			oflow_q <= ovf_q;
		end
	end

	assign valid       = ov_q;
	assign sum_digit   = dig_q;
	assign last_of_sum = last_q;
	assign overflow    = oflow_q;
	assign busy        = act_q | ov_q;

endmodule
